/* rtl/ski_pkg.sv */
// Shared types and constants for the scalar keyframe interpolator.
// Depends on nothing; every module in rtl imports it.
`timescale 1ns / 1ps
package ski_pkg;
    localparam logic [1:0] ST_VALUE = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key_time;
        logic [31:0] key_value;
        logic        step;
    } t_cmd;
endpackage

/* rtl/ski_front.sv */
// Front end: accepts command beats and queues them for the engine.
// Depends on ski_pkg.
`timescale 1ns / 1ps
module ski_front
    import ski_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_take
);
    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= i_cmd;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue count overflow");
    a_no_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_pop |=> o_full) else $error("full lost without pop");
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !i_push |=> !o_valid) else $error("item appeared");
`endif
endmodule

/* rtl/ski_engine.sv */
// Back end: keyframe table, ordered insert and segment search with interpolation.
// Depends on ski_pkg.
`timescale 1ns / 1ps
module ski_engine
    import ski_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_take,
    output logic        o_res_valid,
    output logic [31:0] o_value,
    output logic [1:0]  o_status,
    input  logic        i_res_pop
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR,
        S_EV_RD, S_EV_CMP, S_EV_DIV, S_EV_MUL, S_EV_ADD, S_OUT
    } t_state;

    logic [65:0] r_mem [MAX_KEYS];
    t_state      r_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [65:0] r_rd;
    logic [65:0] r_a;
    logic [65:0] r_b;
    logic [31:0] r_value;
    logic [1:0]  r_status;
    logic [31:0] r_out_value;
    logic [1:0]  r_out_status;
    logic        r_res_valid;
    logic signed [31:0] r_last_time;
    logic [31:0] r_last_value;
    logic [32:0] r_span;
    logic [33:0] r_rem;
    logic [16:0] r_frac;
    logic [4:0]  r_bit;
    logic signed [50:0] r_prod;

    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic [65:0] w_wdata;
    logic        w_we;
    logic        w_load;
    logic signed [31:0] w_rt, w_at, w_qt;
    logic signed [32:0] w_span, w_dist, w_dv;
    logic [34:0] w_trial;

    assign o_res_valid = r_res_valid;
    assign o_value = r_out_value;
    assign o_status = r_out_status;
    assign o_take = (r_state == S_IDLE) && i_valid;
    assign w_rt = signed'(r_rd[65:34]);
    assign w_at = signed'(r_a[65:34]);
    assign w_qt = signed'(r_cmd.key_time);
    assign w_span = $signed({w_rt[31], w_rt}) - $signed({w_at[31], w_at});
    assign w_dist = $signed({w_qt[31], w_qt}) - $signed({w_at[31], w_at});
    assign w_dv = $signed({r_b[33], r_b[33:2]}) - $signed({r_a[33], r_a[33:2]});
    assign w_trial = {1'b0, r_rem} - {2'b00, r_span};
    assign w_raddr = r_idx[AW-1:0];
    assign w_load = (r_state == S_OUT) && (!r_res_valid || i_res_pop);

    // Table writes: a shifted entry during the compare, the new key at the end.
    assign w_we = ((r_state == S_INS_CMP) && (w_rt > w_qt)) || (r_state == S_INS_WR);
    assign w_waddr = (r_state == S_INS_CMP) ? AW'(r_idx + 1'b1) : w_raddr;
    assign w_wdata = (r_state == S_INS_CMP) ? r_rd
                   : {r_cmd.key_time, r_cmd.key_value, r_cmd.step, 1'b0};

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    // Sequencer. Insert compares entries from the tail, shifting later ones up;
    // evaluate scans from entry 0, then runs a restoring divide and multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_res_valid <= 1'b0;
        end else begin
            // The result register is refilled only when free or being popped.
            if (w_load) begin
                r_res_valid <= 1'b1;
                r_out_value <= r_value;
                r_out_status <= r_status;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_value <= '0;
                        if (i_cmd.cmd == CMD_ADD) begin
                            if (r_cnt == CW'(MAX_KEYS)) begin
                                r_status <= ST_FULL;
                                r_state <= S_OUT;
                            end else if (r_cnt == '0) begin
                                r_idx <= '0;
                                r_state <= S_INS_WR;
                            end else begin
                                r_idx <= r_cnt - 1'b1;
                                r_state <= S_INS_RD;
                            end
                        end else if (r_cnt == '0) begin
                            r_status <= ST_EMPTY;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= '0;
                            r_status <= ST_VALUE;
                            r_state <= S_EV_RD;
                        end
                    end
                end
                S_INS_RD: r_state <= S_INS_CMP;
                S_INS_CMP: begin
                    if (w_rt > w_qt) begin
                        if (r_idx == '0) begin
                            r_state <= S_INS_WR;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                            r_state <= S_INS_RD;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    // A key at or after the last time becomes the new last key.
                    if (r_cnt == '0 || w_qt >= r_last_time) begin
                        r_last_time <= w_qt;
                        r_last_value <= r_cmd.key_value;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    r_status <= ST_STORED;
                    r_state <= S_OUT;
                end
                S_EV_RD: r_state <= S_EV_CMP;
                S_EV_CMP: begin
                    // A time at or before entry 0 gives the first value, one at
                    // or after the last key the last value; otherwise a segment
                    // is found once the query is at or below r_rd.
                    if (r_idx == '0) begin
                        if (w_qt <= w_rt || r_cnt == CW'(1)) begin
                            r_value <= r_rd[33:2];
                            r_state <= S_OUT;
                        end else if (w_qt >= r_last_time) begin
                            r_value <= r_last_value;
                            r_state <= S_OUT;
                        end else begin
                            r_a <= r_rd;
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_EV_RD;
                        end
                    end else if (w_qt <= w_rt) begin
                        if (r_a[1] || w_rt <= w_at) begin
                            r_value <= r_a[33:2];
                            r_state <= S_OUT;
                        end else begin
                            r_span <= unsigned'(w_span);
                            r_rem <= {1'b0, w_dist};
                            r_frac <= '0;
                            r_bit <= 5'd16;
                            r_b <= r_rd;
                            r_state <= S_EV_DIV;
                        end
                    end else if (r_idx == r_cnt - 1'b1) begin
                        r_value <= r_rd[33:2];
                        r_state <= S_OUT;
                    end else begin
                        r_a <= r_rd;
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_EV_RD;
                    end
                end
                S_EV_DIV: begin
                    // Restoring divide of ((t - a) << 16) by the span, one
                    // quotient bit per cycle; the quotient fits in 17 bits.
                    r_frac <= {r_frac[15:0], ~w_trial[34]};
                    if (r_bit == '0) begin
                        r_state <= S_EV_MUL;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        r_rem <= w_trial[34] ? {r_rem[32:0], 1'b0} : {w_trial[32:0], 1'b0};
                    end
                end
                S_EV_MUL: begin
                    r_prod <= 51'(w_dv) * $signed({34'd0, r_frac});
                    r_state <= S_EV_ADD;
                end
                S_EV_ADD: begin
                    r_value <= 32'($signed(r_a[33:2]) + (r_prod >>> 16));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEYS)) else $error("key count above table size");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == S_IDLE) else $error("take outside idle");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_pop |=> r_res_valid && $stable(r_out_value))
        else $error("result changed while waiting");
`endif
endmodule

/* rtl/scalar_keyframe_interpolator_core.sv */
// Scalar keyframe interpolator: a sorted keyframe table with linear interpolation.
// Top level; instantiates ski_front and ski_engine, depends on ski_pkg.
//
// Usage: command beats enter through push/full, one result beat leaves
// through empty/pop per command. An add inserts a key in time order and
// answers status 1, or 3 with the key dropped when the table holds MAX_KEYS.
// An evaluate answers the interpolated value with status 0, or status 2 on
// an empty table. A two-beat command queue sits in front of the engine.
// An add compares keys one at a time from the tail, shifting each later key
// up, then writes the new key; an evaluate scans keys from entry 0 and, when
// it interpolates, runs a divide for the 17-bit fraction, a multiply and an add.
// Both walk the keys serially over the single-read-port table, and the
// divider yields one bit per cycle. Items are handled one at a time; the next queued
// command starts in the cycle after the previous result is handed over.
// The result register holds a beat while empty is low; the engine waits in
// its output state until it is popped, and the queue fills behind it.
// Reset (synchronous, active low) empties the queue and the table; stored
// key contents are not cleared.
`timescale 1ns / 1ps
module scalar_keyframe_interpolator_core
    import ski_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_key_value,
    input  logic        i_step_mode,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_out_value,
    output logic [1:0]  o_status
);
    t_cmd w_in, w_q;
    logic w_qv, w_take, w_rv;

    assign w_in = '{cmd: i_command, key_time: i_key_time,
                    key_value: i_key_value, step: i_step_mode};
    assign empty = !w_rv;

    ski_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(w_in), .o_valid(w_qv), .o_cmd(w_q), .i_take(w_take)
    );

    ski_engine #(.MAX_KEYS(MAX_KEYS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_cmd(w_q),
        .o_take(w_take), .o_res_valid(w_rv), .o_value(o_out_value),
        .o_status(o_status), .i_res_pop(pop)
    );
endmodule

/* tb/sv/ski_checker.sv */
// Checker for the scalar keyframe interpolator: watches both queue channels,
// predicts every result beat from its own keyframe table and compares. Needs ski_pkg.
`timescale 1ns / 1ps
module ski_checker
    import ski_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_command,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_key_value,
    input  logic        i_step_mode,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_out_value,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);
    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } t_answer;

    // Keyframe table mirror, sorted by time.
    longint  key_times[MAX_KEYS];
    longint  key_values[MAX_KEYS];
    bit      key_steps[MAX_KEYS];
    int      key_count = 0;
    t_answer answers_due[$];
    int      beat_index = 0;
    int      error_count = 0;
    int      pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result beat %0d: %s got %h expected %h",
                 beat_index, what, got, want);
        error_count++;
    endtask

    // Linear interpolation inside the segment that starts at key idx.
    function automatic longint blend_segment(int idx, longint t);
        longint ta, tb, va, vb;
        longint unsigned frac;
        ta = key_times[idx];
        tb = key_times[idx + 1];
        va = key_values[idx];
        vb = key_values[idx + 1];
        if (key_steps[idx] || tb <= ta) return va;
        frac = (longint'(t - ta) << 16) / longint'(tb - ta);
        return va + (((vb - va) * longint'(frac)) >>> 16);
    endfunction

    function automatic longint value_at(longint t);
        if (key_count == 1 || t <= key_times[0]) return key_values[0];
        if (t >= key_times[key_count - 1]) return key_values[key_count - 1];
        for (int i = 0; i + 1 < key_count; i++) begin
            if (t >= key_times[i] && t <= key_times[i + 1]) return blend_segment(i, t);
        end
        return key_values[key_count - 1];
    endfunction

    // Work out the answer to one accepted command and update the table.
    function automatic t_answer answer_command(logic cmd, logic [31:0] kt,
                                               logic [31:0] kv, logic stp);
        t_answer a;
        longint t;
        int pos;
        a.value = '0;
        t = longint'($signed(kt));
        if (cmd == CMD_ADD) begin
            if (key_count >= MAX_KEYS) begin
                a.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < key_count && key_times[pos] <= t) pos++;
                for (int j = key_count; j > pos; j--) begin
                    key_times[j]  = key_times[j - 1];
                    key_values[j] = key_values[j - 1];
                    key_steps[j]  = key_steps[j - 1];
                end
                key_times[pos]  = t;
                key_values[pos] = longint'($signed(kv));
                key_steps[pos]  = stp;
                key_count++;
                a.status = ST_STORED;
            end
        end else if (key_count == 0) begin
            a.status = ST_EMPTY;
        end else begin
            a.value  = 32'(value_at(t));
            a.status = ST_VALUE;
        end
        return a;
    endfunction

    // Predict on accepted commands, compare on accepted results.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_push && !i_full)
                answers_due.insert(answers_due.size(),
                                   answer_command(i_command, i_key_time,
                                                  i_key_value, i_step_mode));
            if (i_pop && !i_empty) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", i_out_value, 32'(i_status));
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_out_value !== want.value)
                        report_mismatch("value", i_out_value, want.value);
                end
                beat_index++;
            end
            pending_count = answers_due.size();
        end
    end
endmodule

/* tb/sv/testbench.sv */
// Top of the keyframe interpolator testbench: clock, reset, command stimulus,
// result draining and verdict. Needs ski_pkg, ski_checker and the core RTL.
`timescale 1ns / 1ps
module testbench;
    import ski_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BEATS = 430;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_command = CMD_ADD;
    logic [31:0] i_key_time = '0;
    logic [31:0] i_key_value = '0;
    logic        i_step_mode = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_out_value;
    logic [1:0]  o_status;
    int          errors;
    int          pending;
    bit          calm = 1'b0;
    bit          hold_results = 1'b0;

    scalar_keyframe_interpolator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_command(i_command), .i_key_time(i_key_time), .i_key_value(i_key_value),
        .i_step_mode(i_step_mode), .empty(empty), .pop(pop),
        .o_out_value(o_out_value), .o_status(o_status)
    );

    ski_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_command(i_command), .i_key_time(i_key_time), .i_key_value(i_key_value),
        .i_step_mode(i_step_mode), .i_empty(empty), .i_pop(pop),
        .i_out_value(o_out_value), .i_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offer one command beat and hold it until the block takes it.
    task automatic send_command(logic cmd, logic [31:0] kt, logic [31:0] kv, logic stp);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_command   <= cmd;
        i_key_time  <= kt;
        i_key_value <= kv;
        i_step_mode <= stp;
        do @(posedge i_clk); while (full);
    endtask

    // Times mostly come from a narrow window so that queries hit segments
    // and equal times happen; now and then any 32-bit time is used.
    function automatic logic [31:0] pick_time();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 4000)) - 2000) <<< $urandom_range(0, 14);
    endfunction

    // Result side: random stall bursts and one long hold-off on request.
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 14);
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[scalar_keyframe_interpolator_core] ERROR");
                $finish;
            end
        end
    end

    // Directed commands, then random ones, then drain and verdict.
    initial begin
        int wait_cycles;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, single key, extremes and equal times.
        send_command(CMD_EVAL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_ADD, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_command(CMD_EVAL, 32'h8000_0000, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_command(CMD_ADD, 32'h0001_0000, 32'h8000_0000, 1'b0);
        send_command(CMD_EVAL, 32'h0000_8000, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h0000_0001, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h0000_FFFF, 32'h0, 1'b0);
        send_command(CMD_ADD, 32'h0001_0000, 32'h1234_5678, 1'b1);
        send_command(CMD_ADD, 32'h0003_0000, 32'h0000_0000, 1'b0);
        send_command(CMD_EVAL, 32'h0001_0000, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h0002_0000, 32'h0, 1'b0);
        send_command(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_command(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_command(CMD_EVAL, 32'hC000_0000, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h4000_0000, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h7FFF_FFFE, 32'h0, 1'b0);
        send_command(CMD_EVAL, 32'h8000_0001, 32'h0, 1'b0);
        send_command(CMD_ADD, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
        send_command(CMD_EVAL, 32'hFFFF_8000, 32'h0, 1'b0);

        // Random part: adds and evaluates are equally likely until the table
        // fills, then mostly evaluates with some dropped adds.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 120) hold_results = 1'b1;
            if (n == 250) begin
                push <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if (n >= RANDOM_BEATS - 60) calm = 1'b1;
            if ($urandom_range(0, 99) < (chk.key_count < 64 ? 50 : 15))
                send_command(CMD_ADD, pick_time(), $urandom(), 1'($urandom()));
            else
                send_command(CMD_EVAL, pick_time(), $urandom(), 1'($urandom()));
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[scalar_keyframe_interpolator_core] OK");
        end else begin
            $display("[scalar_keyframe_interpolator_core] ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/ski_pkg.sv
rtl/ski_front.sv
rtl/ski_engine.sv
rtl/scalar_keyframe_interpolator_core.sv
tb/sv/ski_checker.sv
tb/sv/testbench.sv
